[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/core/tarpd_pkg.sv]
`default_nettype none

package tarpd_pkg;

  localparam int DATA_W    = 16;
  localparam int OUT_W     = 15;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  // operand A holds err<<F + derr*kd, which fits 32 bits for F up to 14
  localparam int OPA_W     = 32;
  localparam int PROD_W    = OPA_W + DATA_W;

  localparam int COMMAND_LIMIT_DEF      = 9600;
  localparam int GAIN_FRACTION_BITS_DEF = 8;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROLL_P     = 3'd0,
    REG_ROLL_D     = 3'd1,
    REG_PITCH_P    = 3'd2,
    REG_PITCH_D    = 3'd3,
    REG_YAW_P      = 3'd4,
    REG_ROLL_SCALE = 3'd5,
    REG_PITCH_SCALE = 3'd6,
    REG_YAW_SCALE  = 3'd7
  } reg_idx_t;

  localparam logic [DATA_W-1:0] CFG_RESET [NUM_REGS] = '{
    16'd256, 16'd0, 16'd256, 16'd0, 16'd256, 16'd256, 16'd256, 16'd256
  };

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MSEL_ROLL_D,
    MSEL_ROLL_P,
    MSEL_PITCH_D,
    MSEL_PITCH_P,
    MSEL_YAW,
    MSEL_SP_ROLL,
    MSEL_SP_PITCH,
    MSEL_SP_YAW
  } msel_t;

  // write-back targets for the saturated value
  typedef enum logic [2:0] {
    WB_NONE,
    WB_ROLL_CMD,
    WB_PITCH_CMD,
    WB_YAW_CMD,
    WB_TGT_ROLL,
    WB_TGT_PITCH,
    WB_TGT_YAW
  } wb_t;

  typedef struct packed {
    logic  load;      // capture the accepted item
    logic  mul_en;    // register a product
    msel_t msel;
    logic  s_roll;    // roll PD sum from product
    logic  s_pitch;   // pitch PD sum from product
    logic  post_en;   // truncate and saturate product
    logic  post_2f;   // shift by 2F instead of F
    wb_t   wb;
    logic  out_load;  // move results to the output registers
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/tarpd_dp.sv]
`default_nettype none

module tarpd_dp #(
  parameter int COMMAND_LIMIT      = tarpd_pkg::COMMAND_LIMIT_DEF,
  parameter int GAIN_FRACTION_BITS = tarpd_pkg::GAIN_FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tarpd_pkg::cmd_t                        cmd,
  input  logic                                   cfg_write,
  input  logic [tarpd_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [tarpd_pkg::DATA_W-1:0]           cfg_data,
  input  logic                                   mode,
  input  logic signed [tarpd_pkg::DATA_W-1:0]    roll_rate,
  input  logic signed [tarpd_pkg::DATA_W-1:0]    pitch_rate,
  input  logic signed [tarpd_pkg::DATA_W-1:0]    yaw_rate,
  input  logic signed [tarpd_pkg::DATA_W-1:0]    stick_roll,
  input  logic signed [tarpd_pkg::DATA_W-1:0]    stick_pitch,
  input  logic signed [tarpd_pkg::DATA_W-1:0]    stick_yaw,
  input  logic signed [tarpd_pkg::DATA_W-1:0]    radio_throttle,
  output logic signed [tarpd_pkg::OUT_W-1:0]     roll_command,
  output logic signed [tarpd_pkg::OUT_W-1:0]     pitch_command,
  output logic signed [tarpd_pkg::OUT_W-1:0]     yaw_command,
  output logic signed [tarpd_pkg::OUT_W-1:0]     throttle_command
);
  import tarpd_pkg::*;

  localparam int F  = GAIN_FRACTION_BITS;
  localparam int F2 = 2 * GAIN_FRACTION_BITS;
  localparam logic signed [PROD_W-1:0] BIAS_F  = PROD_W'((64'sd1 <<< F) - 64'sd1);
  localparam logic signed [PROD_W-1:0] BIAS_2F = PROD_W'((64'sd1 <<< F2) - 64'sd1);
  localparam logic signed [PROD_W-1:0] SAT_HI  = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO  = -PROD_W'(32768);
  localparam logic signed [DATA_W-1:0] LIM     = DATA_W'(COMMAND_LIMIT);

  function automatic logic signed [DATA_W-1:0] clamp_cmd(input logic signed [DATA_W-1:0] x);
    if (x > LIM) begin
      return LIM;
    end else if (x < -LIM) begin
      return -LIM;
    end
    return x;
  endfunction

  logic signed [DATA_W-1:0] cfg_reg [NUM_REGS];

  logic signed [DATA_W-1:0] target_roll, target_pitch, target_yaw, target_throttle;
  logic signed [DATA_W-1:0] prev_roll, prev_pitch;

  logic signed [DATA_W-1:0] err_roll, err_pitch, err_yaw, derr_roll, derr_pitch;
  logic signed [DATA_W-1:0] stick_roll_r, stick_pitch_r, stick_yaw_r;
  logic signed [DATA_W-1:0] err_roll_next, err_pitch_next, derr_roll_next, derr_pitch_next;

  logic signed [OPA_W-1:0]  s_acc;
  logic signed [OPA_W-1:0]  mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] post_sum, post_shift;
  logic signed [DATA_W-1:0] sat_r, sat_next;
  logic signed [DATA_W-1:0] roll_w, pitch_w, yaw_w, thr_clamped;

  // errors wrap to 16 bits
  assign err_roll_next   = roll_rate - target_roll;
  assign err_pitch_next  = pitch_rate - target_pitch;
  assign derr_roll_next  = err_roll_next - prev_roll;
  assign derr_pitch_next = err_pitch_next - prev_pitch;

  // configuration and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_reg[i] <= CFG_RESET[i];
      end
      target_roll     <= '0;
      target_pitch    <= '0;
      target_yaw      <= '0;
      target_throttle <= '0;
      prev_roll       <= '0;
      prev_pitch      <= '0;
    end else begin
      if (cfg_write) begin
        cfg_reg[cfg_index] <= cfg_data;
      end
      if (cmd.load) begin
        if (mode) begin
          prev_roll  <= err_roll_next;
          prev_pitch <= err_pitch_next;
        end else begin
          target_throttle <= radio_throttle;
        end
      end
      case (cmd.wb)
        WB_TGT_ROLL:  target_roll  <= sat_r;
        WB_TGT_PITCH: target_pitch <= sat_r;
        WB_TGT_YAW:   target_yaw   <= sat_r;
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.msel)
      MSEL_ROLL_D: begin
        mul_a = OPA_W'(derr_roll);
        mul_b = cfg_reg[REG_ROLL_D];
      end
      MSEL_ROLL_P: begin
        mul_a = s_acc;
        mul_b = cfg_reg[REG_ROLL_P];
      end
      MSEL_PITCH_D: begin
        mul_a = OPA_W'(derr_pitch);
        mul_b = cfg_reg[REG_PITCH_D];
      end
      MSEL_PITCH_P: begin
        mul_a = s_acc;
        mul_b = cfg_reg[REG_PITCH_P];
      end
      MSEL_YAW: begin
        mul_a = OPA_W'(err_yaw);
        mul_b = cfg_reg[REG_YAW_P];
      end
      MSEL_SP_ROLL: begin
        mul_a = OPA_W'(stick_roll_r);
        mul_b = cfg_reg[REG_ROLL_SCALE];
      end
      MSEL_SP_PITCH: begin
        mul_a = OPA_W'(stick_pitch_r);
        mul_b = cfg_reg[REG_PITCH_SCALE];
      end
      MSEL_SP_YAW: begin
        mul_a = OPA_W'(stick_yaw_r);
        mul_b = cfg_reg[REG_YAW_SCALE];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // truncate toward zero: bias negative values before the arithmetic shift
  always_comb begin
    post_sum   = prod + (prod[PROD_W-1] ? (cmd.post_2f ? BIAS_2F : BIAS_F) : '0);
    post_shift = cmd.post_2f ? (post_sum >>> F2) : (post_sum >>> F);
    if (post_shift > SAT_HI) begin
      sat_next = SAT_HI[DATA_W-1:0];
    end else if (post_shift < SAT_LO) begin
      sat_next = SAT_LO[DATA_W-1:0];
    end else begin
      sat_next = post_shift[DATA_W-1:0];
    end
  end

  assign thr_clamped = clamp_cmd(target_throttle);

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_roll      <= err_roll_next;
      err_pitch     <= err_pitch_next;
      derr_roll     <= derr_roll_next;
      derr_pitch    <= derr_pitch_next;
      err_yaw       <= yaw_rate - target_yaw;
      stick_roll_r  <= stick_roll;
      stick_pitch_r <= stick_pitch;
      stick_yaw_r   <= stick_yaw;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.s_roll) begin
      s_acc <= $signed(prod[OPA_W-1:0]) + (OPA_W'(err_roll) <<< F);
    end else if (cmd.s_pitch) begin
      s_acc <= $signed(prod[OPA_W-1:0]) + (OPA_W'(err_pitch) <<< F);
    end
    if (cmd.post_en) begin
      sat_r <= sat_next;
    end
    case (cmd.wb)
      WB_ROLL_CMD:  roll_w  <= clamp_cmd(sat_r);
      WB_PITCH_CMD: pitch_w <= clamp_cmd(sat_r);
      WB_YAW_CMD:   yaw_w   <= clamp_cmd(sat_r);
      default: ;
    endcase
    if (cmd.out_load) begin
      roll_command     <= roll_w[OUT_W-1:0];
      pitch_command    <= pitch_w[OUT_W-1:0];
      yaw_command      <= yaw_w[OUT_W-1:0];
      throttle_command <= thr_clamped[OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/core/tarpd_ctrl.sv]
`default_nettype none

module tarpd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            mode,
  input  logic            out_stall,
  output logic            in_stall,
  output logic            out_valid,
  output tarpd_pkg::cmd_t cmd
);
  import tarpd_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_RD   = 15'b000000000000010,  // roll derr*kd
    ST_RS   = 15'b000000000000100,  // roll sum
    ST_RP   = 15'b000000000001000,  // roll sum*kp
    ST_PD   = 15'b000000000010000,  // pitch derr*kd, roll post
    ST_PS   = 15'b000000000100000,  // pitch sum, roll write-back
    ST_PP   = 15'b000000001000000,  // pitch sum*kp
    ST_YM   = 15'b000000010000000,  // yaw err*kp, pitch post
    ST_PW   = 15'b000000100000000,  // yaw post, pitch write-back
    ST_YW   = 15'b000001000000000,  // yaw write-back
    ST_OUT  = 15'b000010000000000,  // wait for output register
    ST_SR   = 15'b000100000000000,  // setpoint roll multiply
    ST_SP   = 15'b001000000000000,
    ST_SY   = 15'b010000000000000,
    ST_SW   = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   sp_yaw_wb;  // last setpoint write-back, in the cycle after ST_SW

  assign in_stall = (state != ST_IDLE) || sp_yaw_wb;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load   = 1'b1;
          state_next = mode ? ST_RD : ST_SR;
        end
      end
      ST_RD: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = MSEL_ROLL_D;
        state_next = ST_RS;
      end
      ST_RS: begin
        cmd.s_roll = 1'b1;
        state_next = ST_RP;
      end
      ST_RP: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = MSEL_ROLL_P;
        state_next = ST_PD;
      end
      ST_PD: begin
        cmd.mul_en  = 1'b1;
        cmd.msel    = MSEL_PITCH_D;
        cmd.post_en = 1'b1;
        cmd.post_2f = 1'b1;
        state_next  = ST_PS;
      end
      ST_PS: begin
        cmd.s_pitch = 1'b1;
        cmd.wb      = WB_ROLL_CMD;
        state_next  = ST_PP;
      end
      ST_PP: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = MSEL_PITCH_P;
        state_next = ST_YM;
      end
      ST_YM: begin
        cmd.mul_en  = 1'b1;
        cmd.msel    = MSEL_YAW;
        cmd.post_en = 1'b1;
        cmd.post_2f = 1'b1;
        state_next  = ST_PW;
      end
      ST_PW: begin
        cmd.post_en = 1'b1;
        cmd.wb      = WB_PITCH_CMD;
        state_next  = ST_YW;
      end
      ST_YW: begin
        cmd.wb     = WB_YAW_CMD;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SR: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = MSEL_SP_ROLL;
        state_next = ST_SP;
      end
      ST_SP: begin
        cmd.mul_en  = 1'b1;
        cmd.msel    = MSEL_SP_PITCH;
        cmd.post_en = 1'b1;
        state_next  = ST_SY;
      end
      ST_SY: begin
        cmd.mul_en  = 1'b1;
        cmd.msel    = MSEL_SP_YAW;
        cmd.post_en = 1'b1;
        cmd.wb      = WB_TGT_ROLL;
        state_next  = ST_SW;
      end
      ST_SW: begin
        cmd.post_en = 1'b1;
        cmd.wb      = WB_TGT_PITCH;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // yaw target lands while the state machine is already back in idle
    if (sp_yaw_wb) begin
      cmd.wb = WB_TGT_YAW;
    end
  end

  assign out_valid_next = cmd.out_load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      sp_yaw_wb <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      sp_yaw_wb <= (state == ST_SW);
    end
  end

endmodule

`default_nettype wire

[rtl/core/three_axis_rate_pd_controller_unit.sv]
`default_nettype none

// Three-axis rate PD controller. An item with mode 0 scales the radio roll,
// pitch and yaw by their Q.F setpoint scales (truncated toward zero,
// saturated to 16 bits) into the target rates and stores the throttle; it
// gives no result, and the next item is not accepted until the yaw target
// has been written back. An item with mode 1 runs a PD law on roll and pitch
// ((err*2^F + derr*kd)*kp / 2^2F) and a P law on yaw (err*kp / 2^F), each
// saturated to 16 bits and clamped to +/-COMMAND_LIMIT; the stored throttle is
// clamped the same way. Its result becomes valid after the yaw write-back,
// later while the previous result is still held in the output register, and
// the next item can be accepted in the cycle the result becomes valid. One
// item is in work at a time; every product goes through a single shared 32x16
// multiplier with a registered product, and five products per control step
// set the latency. A finished result waits in the output register while the
// next item is taken. Write gains through cfg_write/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce this.

`include "assert_macros.svh"

module three_axis_rate_pd_controller_unit #(
  parameter int COMMAND_LIMIT      = tarpd_pkg::COMMAND_LIMIT_DEF,
  parameter int GAIN_FRACTION_BITS = tarpd_pkg::GAIN_FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [tarpd_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [tarpd_pkg::DATA_W-1:0]        cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic signed [tarpd_pkg::DATA_W-1:0] roll_rate,
  input  logic signed [tarpd_pkg::DATA_W-1:0] pitch_rate,
  input  logic signed [tarpd_pkg::DATA_W-1:0] yaw_rate,
  input  logic signed [tarpd_pkg::DATA_W-1:0] stick_roll,
  input  logic signed [tarpd_pkg::DATA_W-1:0] stick_pitch,
  input  logic signed [tarpd_pkg::DATA_W-1:0] stick_yaw,
  input  logic signed [tarpd_pkg::DATA_W-1:0] radio_throttle,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tarpd_pkg::OUT_W-1:0]  roll_command,
  output logic signed [tarpd_pkg::OUT_W-1:0]  pitch_command,
  output logic signed [tarpd_pkg::OUT_W-1:0]  yaw_command,
  output logic signed [tarpd_pkg::OUT_W-1:0]  throttle_command
);
  import tarpd_pkg::*;

  localparam logic signed [DATA_W-1:0] CMD_LIM = DATA_W'(COMMAND_LIMIT);

  cmd_t cmd;

  // sequencer: one state per multiply / sum / write-back step
  tarpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // gains, state, shared multiplier and output registers
  tarpd_dp #(
    .COMMAND_LIMIT      (COMMAND_LIMIT),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mode             (mode),
    .roll_rate        (roll_rate),
    .pitch_rate       (pitch_rate),
    .yaw_rate         (yaw_rate),
    .stick_roll       (stick_roll),
    .stick_pitch      (stick_pitch),
    .stick_yaw        (stick_yaw),
    .radio_throttle   (radio_throttle),
    .roll_command     (roll_command),
    .pitch_command    (pitch_command),
    .yaw_command      (yaw_command),
    .throttle_command (throttle_command)
  );

  // an accepted item keeps the block busy on the next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // a new result never overwrites one still waiting to be taken
  `ASSERT_SAME(a_no_overwrite, clk, rst, cmd.out_load, !out_valid || !out_stall)

  // delivered commands stay inside the limit
  `ASSERT_SAME(a_cmd_in_limit, clk, rst, out_valid,
    (roll_command <= CMD_LIM) && (roll_command >= -CMD_LIM) &&
    (pitch_command <= CMD_LIM) && (pitch_command >= -CMD_LIM) &&
    (yaw_command <= CMD_LIM) && (yaw_command >= -CMD_LIM) &&
    (throttle_command <= CMD_LIM) && (throttle_command >= -CMD_LIM))

endmodule

`default_nettype wire
